@@ src/mcde_pkg.sv @@
// Shared constants and types for the multi-channel debounce event unit.
package mcde_pkg;

	// Field widths fixed by the interface.
	localparam int CHAN_W  = 4;
	localparam int TIME_W  = 32;
	localparam int PBASE_W = 8;
	localparam int PIN_W   = 9;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 32;

	// Defaults.
	localparam int CHANNELS_DEF = 16;
	localparam logic [TIME_W-1:0]  DEBOUNCE_RESET = 32'd25;
	localparam logic [PBASE_W-1:0] PIN_BASE_RESET = 8'd31;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_DELAY = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PIN_BASE       = 8'd1;

	// One channel sample.
	typedef struct packed {
		logic [CHAN_W-1:0] channel;
		logic              level;
		logic [TIME_W-1:0] now_ms;
	} sample_t;

	// Commit request from the sample stage to the channel bank.
	typedef struct packed {
		logic    upd;
		sample_t smp;
	} bank_req_t;

endpackage

@@ src/mcde_if.sv @@
// Handshake channel interfaces for samples, events and register writes.
interface mcde_sample_if;
	logic                            valid;
	logic                            ready;
	logic [mcde_pkg::CHAN_W-1:0]     channel;
	logic                            level;
	logic [mcde_pkg::TIME_W-1:0]     now_ms;

	modport source (output valid, output channel, output level, output now_ms, input ready);
	modport sink   (input valid, input channel, input level, input now_ms, output ready);
endinterface

interface mcde_event_if;
	logic                            valid;
	logic                            ready;
	logic [mcde_pkg::PIN_W-1:0]      pin_number;

	modport source (output valid, output pin_number, input ready);
	modport sink   (input valid, input pin_number, output ready);
endinterface

interface mcde_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [mcde_pkg::CFG_IDX_W-1:0]    index;
	logic [mcde_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

@@ src/multi_channel_debounce_events_unit.sv @@
// Top level: sample register, channel bank, event register and registers.
// Path: the accepting edge loads the sample register; a rising settle from it
// then loads the event register, unless a held event not yet taken stalls
// the sample register. Throughput: one sample per cycle, limited only by the
// single event register when the event side stalls.
// Reset (arst_n low, asynchronous): all channel stores clear to zero, both
// pipeline registers empty, debounce_delay returns to 25 and pin_base to 31.
module multi_channel_debounce_events_unit #(
	parameter int CHANNELS = mcde_pkg::CHANNELS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	mcde_sample_if.sink      smp,
	mcde_event_if.source     evt,
	mcde_cfg_if.sink         cfg
);

	logic [mcde_pkg::TIME_W-1:0]   debounce_delay_q;
	logic [mcde_pkg::PBASE_W-1:0]  pin_base_q;

	logic                          v_s1;
	mcde_pkg::sample_t             smp_s1;
	logic                          evt_v_q;
	logic [mcde_pkg::PIN_W-1:0]    pin_q;

	logic                          rise;
	logic                          adv;
	mcde_pkg::bank_req_t           req;

	// Take register writes at any time.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_delay_q <= mcde_pkg::DEBOUNCE_RESET;
			pin_base_q       <= mcde_pkg::PIN_BASE_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				mcde_pkg::REG_DEBOUNCE_DELAY: debounce_delay_q <= cfg.data;
				mcde_pkg::REG_PIN_BASE:       pin_base_q <= cfg.data[mcde_pkg::PBASE_W-1:0];
				default: ;
			endcase
		end
	end

	// Advance the sample stage unless its event would collide with a held one.
	assign adv       = v_s1 && (!rise || !evt_v_q || evt.ready);
	assign smp.ready = !v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (smp.ready) begin
			v_s1 <= smp.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (smp.valid && smp.ready) begin
			smp_s1.channel <= smp.channel;
			smp_s1.level   <= smp.level;
			smp_s1.now_ms  <= smp.now_ms;
		end
	end

	assign req.upd = adv;
	assign req.smp = smp_s1;

	mcde_chan_bank #(
		.CHANNELS(CHANNELS)
	) u_bank (
		.clk            (clk),
		.arst_n         (arst_n),
		.req            (req),
		.debounce_delay (debounce_delay_q),
		.rise           (rise)
	);

	// Hold the event until taken; load a new one on a rising settle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			evt_v_q <= 1'b0;
		end else if (adv && rise) begin
			evt_v_q <= 1'b1;
		end else if (evt.ready) begin
			evt_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && rise) begin
			pin_q <= mcde_pkg::PIN_W'(pin_base_q) + mcde_pkg::PIN_W'(smp_s1.channel);
		end
	end

	assign evt.valid      = evt_v_q;
	assign evt.pin_number = pin_q;

	// A rising settle loads the event register with its pin.
	a_evt_load: assert property (@(posedge clk) disable iff (!arst_n)
		adv && rise |=> evt.valid
		&& evt.pin_number == $past(mcde_pkg::PIN_W'(pin_base_q)
		+ mcde_pkg::PIN_W'(smp_s1.channel)))
		else $error("event not loaded");

	// A pending event must not be overwritten.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && rise && evt_v_q && !evt.ready |-> !adv && !smp.ready)
		else $error("held event overwritten");

	// A sample that makes no event never stalls.
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !rise |-> adv && smp.ready)
		else $error("sample stalled without an event");

endmodule

@@ src/mcde_chan_bank.sv @@
// Per-channel debounce stores and the settle decision for one sample.
module mcde_chan_bank #(
	parameter int CHANNELS = mcde_pkg::CHANNELS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mcde_pkg::bank_req_t           req,
	input  logic [mcde_pkg::TIME_W-1:0]   debounce_delay,
	output logic                          rise
);

	localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int CNT_W = $clog2(CHANNELS + 1);
	localparam int CMP_W = CNT_W + mcde_pkg::CHAN_W;

	logic                          prev_q  [CHANNELS];
	logic                          stab_q  [CHANNELS];
	logic [mcde_pkg::TIME_W-1:0]   ctime_q [CHANNELS];

	logic [IDX_W+mcde_pkg::CHAN_W-1:0] ch_ext;
	logic [IDX_W-1:0]                  idx;
	logic                              in_range;
	logic                              steady;
	logic [mcde_pkg::TIME_W-1:0]       elapsed;
	logic                              hit;

	// Decode the channel and evaluate the settle condition.
	always_comb begin
		ch_ext   = {{IDX_W{1'b0}}, req.smp.channel};
		idx      = ch_ext[IDX_W-1:0];
		in_range = ({{CNT_W{1'b0}}, req.smp.channel} < CMP_W'(CHANNELS));
		steady   = (req.smp.level == prev_q[idx]);
		elapsed  = req.smp.now_ms - ctime_q[idx];
		// A raw change restarts the timer, so only a steady level can settle.
		hit      = in_range && steady && (elapsed > debounce_delay)
		           && (req.smp.level != stab_q[idx]);
		rise     = hit && req.smp.level;
	end

	// Commit the channel's stores.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				prev_q[i]  <= 1'b0;
				stab_q[i]  <= 1'b0;
				ctime_q[i] <= '0;
			end
		end else if (req.upd && in_range) begin
			if (!steady) begin
				ctime_q[idx] <= req.smp.now_ms;
			end
			if (hit) begin
				stab_q[idx] <= req.smp.level;
			end
			prev_q[idx] <= req.smp.level;
		end
	end

	// A settle always follows a steady sample.
	a_hit_steady: assert property (@(posedge clk) disable iff (!arst_n)
		req.upd && hit |-> req.smp.level == prev_q[idx])
		else $error("settle on a changing raw level");

	// The stable level takes the raw level after a settle.
	a_hit_commit: assert property (@(posedge clk) disable iff (!arst_n)
		req.upd && hit |=> stab_q[$past(idx)] == $past(req.smp.level))
		else $error("stable level not updated");

	// A new raw level restarts the channel timer.
	a_timer_restart: assert property (@(posedge clk) disable iff (!arst_n)
		req.upd && in_range && !steady |=> ctime_q[$past(idx)] == $past(req.smp.now_ms))
		else $error("change time not restarted");

endmodule
